FILE: hw/rtl/ucer_pkg.sv
package ucer_pkg;

    localparam int EP0_PACKET_BYTES_DEF     = 8;
    localparam int DESCRIPTOR_ROM_BYTES_DEF = 256;

    localparam int ROM_USED = 200;
    localparam int AT_DEV   = 0;
    localparam int AT_CFG   = 18;
    localparam int AT_LANG  = 50;
    localparam int AT_MAN   = 54;
    localparam int AT_PROD  = 136;
    localparam int AT_SER   = 178;
    localparam int AT_LUN   = 200;

    // result kinds
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_ZLP    = 3'd1;
    localparam logic [2:0] KIND_ADDR   = 3'd2;
    localparam logic [2:0] KIND_CONFIG = 3'd3;
    localparam logic [2:0] KIND_SRESET = 3'd4;

    // operations
    localparam logic [1:0] OP_BUS_RESET = 2'd0;
    localparam logic [1:0] OP_SETUP     = 2'd1;
    localparam logic [1:0] OP_IN_DONE   = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    // request types (bmRequestType bits 6-5)
    localparam logic [1:0] RTYPE_STANDARD = 2'd0;
    localparam logic [1:0] RTYPE_CLASS    = 2'd1;

    // request codes
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_DESCRIPTOR    = 8'd7;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
    localparam logic [7:0] REQ_GET_MAX_LUN       = 8'hFE;
    localparam logic [7:0] REQ_STORAGE_RESET     = 8'hFF;

    // descriptor types
    localparam logic [7:0] DESC_DEVICE        = 8'h01;
    localparam logic [7:0] DESC_CONFIGURATION = 8'h02;
    localparam logic [7:0] DESC_STRING        = 8'h03;
    localparam logic [7:0] DESC_REPORT        = 8'h22;

    // command from front to back
    typedef enum logic [2:0] {
        t_CMD_NONE,
        t_CMD_BUS_RESET,
        t_CMD_ABORT,
        t_CMD_REPLY,
        t_CMD_SEND,
        t_CMD_ADDR,
        t_CMD_CONFIG,
        t_CMD_SRESET
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  base;
        logic [6:0]  len;
        logic        zlp;
        logic [7:0]  value;
    } t_job;

    // descriptor bytes below the LUN slot; packet size byte is passed in
    function automatic logic [7:0] rom_byte(input logic [7:0] a, input logic [7:0] pkt);
        logic [7:0] r;
        r = 8'h00;
        unique case (a)
            8'd0: r = 8'h12; 8'd1: r = 8'h01; 8'd2: r = 8'h10; 8'd3: r = 8'h01;
            8'd4: r = 8'h00; 8'd5: r = 8'h00; 8'd6: r = 8'h00; 8'd7: r = pkt;
            8'd8: r = 8'h88; 8'd9: r = 8'h88; 8'd10: r = 8'h09; 8'd11: r = 8'h21;
            8'd12: r = 8'h00; 8'd13: r = 8'h01; 8'd14: r = 8'h01; 8'd15: r = 8'h02;
            8'd16: r = 8'h03; 8'd17: r = 8'h01;
            8'd18: r = 8'h09; 8'd19: r = 8'h02; 8'd20: r = 8'h20; 8'd21: r = 8'h00;
            8'd22: r = 8'h01; 8'd23: r = 8'h01; 8'd24: r = 8'h00; 8'd25: r = 8'h80;
            8'd26: r = 8'h32;
            8'd27: r = 8'h09; 8'd28: r = 8'h04; 8'd29: r = 8'h00; 8'd30: r = 8'h00;
            8'd31: r = 8'h02; 8'd32: r = 8'h08; 8'd33: r = 8'h06; 8'd34: r = 8'h50;
            8'd35: r = 8'h00;
            8'd36: r = 8'h07; 8'd37: r = 8'h05; 8'd38: r = 8'h81; 8'd39: r = 8'h02;
            8'd40: r = 8'h40; 8'd41: r = 8'h00; 8'd42: r = 8'h00;
            8'd43: r = 8'h07; 8'd44: r = 8'h05; 8'd45: r = 8'h02; 8'd46: r = 8'h02;
            8'd47: r = 8'h40; 8'd48: r = 8'h00; 8'd49: r = 8'h00;
            8'd50: r = 8'h04; 8'd51: r = 8'h03; 8'd52: r = 8'h09; 8'd53: r = 8'h04;
            8'd54: r = 8'd82; 8'd55: r = 8'h03; 8'd56: r = 8'h35; 8'd57: r = 8'h75;
            8'd58: r = 8'h11; 8'd59: r = 8'h81; 8'd60: r = 8'h08; 8'd61: r = 8'h57;
            8'd62: r = 8'h08; 8'd63: r = 8'h57; 8'd64: r = 8'h84; 8'd65: r = 8'h76;
            8'd66: r = 8'h55; 8'd67: r = 8'h00; 8'd68: r = 8'h53; 8'd69: r = 8'h00;
            8'd70: r = 8'h42; 8'd71: r = 8'h00; 8'd72: r = 8'h13; 8'd73: r = 8'h4e;
            8'd74: r = 8'h3a; 8'd75: r = 8'h53; 8'd76: r = 8'h20; 8'd77: r = 8'h00;
            8'd78: r = 8'h48; 8'd79: r = 8'h00; 8'd80: r = 8'h74; 8'd81: r = 8'h00;
            8'd82: r = 8'h74; 8'd83: r = 8'h00; 8'd84: r = 8'h70; 8'd85: r = 8'h00;
            8'd86: r = 8'h3a; 8'd87: r = 8'h00; 8'd88: r = 8'h2f; 8'd89: r = 8'h00;
            8'd90: r = 8'h2f; 8'd91: r = 8'h00; 8'd92: r = 8'h67; 8'd93: r = 8'h00;
            8'd94: r = 8'h72; 8'd95: r = 8'h00; 8'd96: r = 8'h6f; 8'd97: r = 8'h00;
            8'd98: r = 8'h75; 8'd99: r = 8'h00; 8'd100: r = 8'h70; 8'd101: r = 8'h00;
            8'd102: r = 8'h2e; 8'd103: r = 8'h00; 8'd104: r = 8'h65; 8'd105: r = 8'h00;
            8'd106: r = 8'h64; 8'd107: r = 8'h00; 8'd108: r = 8'h6e; 8'd109: r = 8'h00;
            8'd110: r = 8'h63; 8'd111: r = 8'h00; 8'd112: r = 8'h68; 8'd113: r = 8'h00;
            8'd114: r = 8'h69; 8'd115: r = 8'h00; 8'd116: r = 8'h6e; 8'd117: r = 8'h00;
            8'd118: r = 8'h61; 8'd119: r = 8'h00; 8'd120: r = 8'h2e; 8'd121: r = 8'h00;
            8'd122: r = 8'h63; 8'd123: r = 8'h00; 8'd124: r = 8'h6f; 8'd125: r = 8'h00;
            8'd126: r = 8'h6d; 8'd127: r = 8'h00; 8'd128: r = 8'h2f; 8'd129: r = 8'h00;
            8'd130: r = 8'h39; 8'd131: r = 8'h00; 8'd132: r = 8'h33; 8'd133: r = 8'h00;
            8'd134: r = 8'h2f; 8'd135: r = 8'h00;
            8'd136: r = 8'd42; 8'd137: r = 8'h03; 8'd138: r = 8'h32; 8'd139: r = 8'h00;
            8'd140: r = 8'h31; 8'd141: r = 8'h00; 8'd142: r = 8'h49; 8'd143: r = 8'h00;
            8'd144: r = 8'h43; 8'd145: r = 8'h00; 8'd146: r = 8'h20; 8'd147: r = 8'h00;
            8'd148: r = 8'h44; 8'd149: r = 8'h00; 8'd150: r = 8'h49; 8'd151: r = 8'h00;
            8'd152: r = 8'h59; 8'd153: r = 8'h00; 8'd154: r = 8'h20; 8'd155: r = 8'h00;
            8'd156: r = 8'h55; 8'd157: r = 8'h00; 8'd158: r = 8'hd8; 8'd159: r = 8'h76;
            8'd160: r = 8'h66; 8'd161: r = 8'h5b; 8'd162: r = 8'h60; 8'd163: r = 8'h4e;
            8'd164: r = 8'h7f; 8'd165: r = 8'h67; 8'd166: r = 8'h20; 8'd167: r = 8'h00;
            8'd168: r = 8'h4b; 8'd169: r = 8'h4e; 8'd170: r = 8'h20; 8'd171: r = 8'h00;
            8'd172: r = 8'h1f; 8'd173: r = 8'h77; 8'd174: r = 8'h55; 8'd175: r = 8'h00;
            8'd176: r = 8'hd8; 8'd177: r = 8'h76;
            8'd178: r = 8'd22; 8'd179: r = 8'h03; 8'd180: r = 8'h32; 8'd181: r = 8'h00;
            8'd182: r = 8'h30; 8'd183: r = 8'h00; 8'd184: r = 8'h30; 8'd185: r = 8'h00;
            8'd186: r = 8'h39; 8'd187: r = 8'h00; 8'd188: r = 8'h2d; 8'd189: r = 8'h00;
            8'd190: r = 8'h30; 8'd191: r = 8'h00; 8'd192: r = 8'h33; 8'd193: r = 8'h00;
            8'd194: r = 8'h2d; 8'd195: r = 8'h00; 8'd196: r = 8'h31; 8'd197: r = 8'h00;
            8'd198: r = 8'h38; 8'd199: r = 8'h00;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/usb_control_endpoint_responder.sv
// USB endpoint-zero responder for a bulk-only storage device. Each item (bus
// reset, setup, IN done) is decoded in the front end and queued; the back end
// then emits its results one per cycle while i_ready takes them: up to the
// packet size of descriptor bytes, a zero-length packet marker, or an
// address/configuration/storage reset action, with o_last on the final one.
// In the back end a data reply or IN done is taken in S_IDLE, its packet is
// decided in S_ZLP and its bytes (at most eight) then leave from S_DATA; an
// action gives two results. A new item is taken while results are still
// leaving, until the four-entry queue fills. The user must write max_lun
// through i_cfg_we/i_cfg_data only while the block is idle; the block itself
// does not enforce it.
module usb_control_endpoint_responder #(
    parameter int EP0_PACKET_BYTES     = ucer_pkg::EP0_PACKET_BYTES_DEF,
    parameter int DESCRIPTOR_ROM_BYTES = ucer_pkg::DESCRIPTOR_ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_setup_byte_count,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_payload,
    output logic        o_last
);
    logic [3:0]     r_max_lun;
    logic           f_valid, f_ready, q_valid, q_ready;
    ucer_pkg::t_job f_job, q_job;

    // hold the LUN register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lun <= '0;
        end else if (i_cfg_we) begin
            r_max_lun <= i_cfg_data;
        end
    end

    ucer_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_operation, .i_setup_byte_count, .i_request_type, .i_request_code,
        .i_request_value, .i_request_length,
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    ucer_queue #(.DEPTH(4)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    ucer_back #(
        .EP0_PACKET_BYTES(EP0_PACKET_BYTES),
        .DESCRIPTOR_ROM_BYTES(DESCRIPTOR_ROM_BYTES)
    ) u_back (
        .i_clk, .i_rst_n, .i_max_lun(r_max_lun),
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .o_valid, .i_ready, .o_kind, .o_payload, .o_last
    );
endmodule

FILE: hw/rtl/ucer_front.sv
// Classify one input item into a job for the back end.
module ucer_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic [4:0]           i_setup_byte_count,
    input  logic [7:0]           i_request_type,
    input  logic [7:0]           i_request_code,
    input  logic [15:0]          i_request_value,
    input  logic [15:0]          i_request_length,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output ucer_pkg::t_job       o_job
);
    logic           r_valid;
    ucer_pkg::t_job r_job;
    ucer_pkg::t_job n_job;

    logic [1:0] rtype;
    logic [7:0] dtype;
    logic [7:0] didx;
    logic [6:0] full_len;
    logic [7:0] base;
    logic       is_reply;
    logic       force_zero;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;
    assign rtype = i_request_type[6:5];
    assign dtype = i_request_value[15:8];
    assign didx  = i_request_value[7:0];

    // decode the item (bus reset, setup, IN done) into a job
    always_comb begin
        n_job      = '0;
        n_job.cmd  = ucer_pkg::t_CMD_NONE;
        n_job.value = i_request_value[7:0];
        is_reply   = 1'b0;
        force_zero = 1'b0;
        base       = 8'd0;
        full_len   = 7'd0;
        unique case (i_operation)
            ucer_pkg::OP_BUS_RESET: n_job.cmd = ucer_pkg::t_CMD_BUS_RESET;
            ucer_pkg::OP_IN_DONE:   n_job.cmd = ucer_pkg::t_CMD_SEND;
            ucer_pkg::OP_SETUP: begin
                if (i_setup_byte_count == 5'd8) begin
                    n_job.cmd = ucer_pkg::t_CMD_ABORT;
                    if (i_request_type[7]) begin
                        if (rtype == ucer_pkg::RTYPE_STANDARD) begin
                            if (i_request_code == ucer_pkg::REQ_GET_DESCRIPTOR) begin
                                unique case (dtype)
                                    ucer_pkg::DESC_DEVICE: begin
                                        is_reply = 1'b1; base = 8'(ucer_pkg::AT_DEV);
                                        full_len = 7'd18;
                                    end
                                    ucer_pkg::DESC_CONFIGURATION: begin
                                        is_reply = 1'b1; base = 8'(ucer_pkg::AT_CFG);
                                        full_len = 7'd32;
                                    end
                                    ucer_pkg::DESC_STRING: begin
                                        is_reply = 1'b1;
                                        unique case (didx)
                                            8'd0: begin
                                                base = 8'(ucer_pkg::AT_LANG); full_len = 7'd4;
                                            end
                                            8'd1: begin
                                                base = 8'(ucer_pkg::AT_MAN); full_len = 7'd82;
                                            end
                                            8'd2: begin
                                                base = 8'(ucer_pkg::AT_PROD); full_len = 7'd42;
                                            end
                                            8'd3: begin
                                                base = 8'(ucer_pkg::AT_SER); full_len = 7'd22;
                                            end
                                            default: force_zero = 1'b1;
                                        endcase
                                    end
                                    ucer_pkg::DESC_REPORT: is_reply = 1'b1;
                                    default: is_reply = 1'b0;
                                endcase
                            end
                        end else if (rtype == ucer_pkg::RTYPE_CLASS) begin
                            is_reply = 1'b1;
                            if (i_request_code == ucer_pkg::REQ_GET_MAX_LUN) begin
                                base = 8'(ucer_pkg::AT_LUN); full_len = 7'd1;
                            end else begin
                                force_zero = 1'b1;
                            end
                        end
                    end else if (rtype == ucer_pkg::RTYPE_STANDARD) begin
                        unique case (i_request_code)
                            ucer_pkg::REQ_CLEAR_FEATURE, ucer_pkg::REQ_SET_FEATURE,
                            ucer_pkg::REQ_SET_DESCRIPTOR, ucer_pkg::REQ_SET_INTERFACE:
                                n_job.cmd = ucer_pkg::t_CMD_ABORT;
                            ucer_pkg::REQ_SET_ADDRESS: n_job.cmd = ucer_pkg::t_CMD_ADDR;
                            ucer_pkg::REQ_SET_CONFIGURATION:
                                n_job.cmd = ucer_pkg::t_CMD_CONFIG;
                            default: begin
                                is_reply = 1'b1; force_zero = 1'b1;
                            end
                        endcase
                    end else if (rtype == ucer_pkg::RTYPE_CLASS) begin
                        if (i_request_code == ucer_pkg::REQ_STORAGE_RESET) begin
                            n_job.cmd = ucer_pkg::t_CMD_SRESET;
                        end else begin
                            is_reply = 1'b1; force_zero = 1'b1;
                        end
                    end
                    // clamp length against wLength; zero packet decided in back end
                    if (is_reply) begin
                        n_job.cmd  = ucer_pkg::t_CMD_REPLY;
                        n_job.base = base;
                        if (i_request_length > 16'(full_len)) begin
                            n_job.len = full_len;
                            n_job.zlp = 1'b1;
                        end else begin
                            n_job.len = i_request_length[6:0];
                            n_job.zlp = 1'b0;
                        end
                        n_job.value = {7'd0, force_zero};
                    end
                end
            end
            default: n_job.cmd = ucer_pkg::t_CMD_NONE;
        endcase
    end

    // hold one job until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

FILE: hw/rtl/ucer_queue.sv
// Short job queue between front and back ends.
module ucer_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ucer_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output ucer_pkg::t_job  o_job
);
    localparam int AW = $clog2(DEPTH);

    ucer_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wr] <= i_job;
    end
endmodule

FILE: hw/rtl/ucer_back.sv
// Carry out jobs: emit results, one per cycle while i_ready takes them, into an output register.
module ucer_back #(
    parameter int EP0_PACKET_BYTES     = ucer_pkg::EP0_PACKET_BYTES_DEF,
    parameter int DESCRIPTOR_ROM_BYTES = ucer_pkg::DESCRIPTOR_ROM_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [3:0]      i_max_lun,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  ucer_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_payload,
    output logic            o_last
);
    localparam int PKT = (EP0_PACKET_BYTES < 1) ? 1 :
                         ((EP0_PACKET_BYTES > 8) ? 8 : EP0_PACKET_BYTES);
    localparam logic [7:0] PKT_B = 8'(PKT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_ZLP,
        S_ADDR
    } t_state;

    t_state     r_state;
    logic [6:0] r_left;
    logic [7:0] r_ptr;
    logic       r_zlp;
    logic [3:0] r_cnt;
    logic [7:0] r_addr;
    logic [7:0] r_cfg;
    logic       r_ovalid;
    logic [2:0] r_kind;
    logic [7:0] r_payload;
    logic       r_last;

    logic       out_free;
    logic [7:0] rd;
    logic [6:0] first_cnt;
    logic       zlp_mod;

    assign out_free    = !r_ovalid || i_ready;
    assign o_job_ready = out_free && r_state == S_IDLE;
    assign o_valid     = r_ovalid;
    assign o_kind      = r_kind;
    assign o_payload   = r_payload;
    assign o_last      = r_last;

    // ROM read with LUN slot and out-of-range zeroes
    always_comb begin
        if (32'(r_ptr) >= DESCRIPTOR_ROM_BYTES) rd = 8'h00;
        else if (r_ptr < 8'(ucer_pkg::ROM_USED)) rd = ucer_pkg::rom_byte(r_ptr, PKT_B);
        else if (r_ptr == 8'(ucer_pkg::AT_LUN)) rd = {4'd0, i_max_lun};
        else rd = 8'h00;
    end

    assign first_cnt = (r_left > 7'(PKT)) ? 7'(PKT) : r_left;
    assign zlp_mod   = (i_job.len % 7'(PKT)) == 7'd0;

    // sequence jobs and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_left   <= '0;
            r_ptr    <= '0;
            r_zlp    <= 1'b0;
            r_cnt    <= '0;
            r_cfg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (out_free) begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_job_valid) begin
                            unique case (i_job.cmd)
                                ucer_pkg::t_CMD_BUS_RESET: begin
                                    r_left <= '0; r_ptr <= '0; r_zlp <= 1'b0; r_cfg <= '0;
                                end
                                ucer_pkg::t_CMD_ABORT: begin
                                    r_left <= '0; r_zlp <= 1'b0;
                                end
                                ucer_pkg::t_CMD_REPLY: begin
                                    r_ptr  <= i_job.base;
                                    r_left <= i_job.len;
                                    r_zlp  <= i_job.value[0] || (i_job.zlp && zlp_mod);
                                    r_state <= S_ZLP;
                                    r_cnt  <= '0;
                                end
                                ucer_pkg::t_CMD_SEND: begin
                                    r_state <= S_ZLP;
                                    r_cnt   <= '0;
                                end
                                ucer_pkg::t_CMD_ADDR: begin
                                    r_left <= '0; r_zlp <= 1'b0;
                                    r_addr <= i_job.value;
                                    r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_ZLP;
                                    r_payload <= '0; r_last <= 1'b0;
                                    r_state <= S_ADDR;
                                end
                                ucer_pkg::t_CMD_CONFIG: begin
                                    r_left <= '0; r_zlp <= 1'b0;
                                    r_cfg <= i_job.value;
                                    r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_CONFIG;
                                    r_payload <= i_job.value; r_last <= 1'b0;
                                    r_state <= S_ZLP;
                                    r_cnt <= 4'd8;
                                end
                                ucer_pkg::t_CMD_SRESET: begin
                                    r_left <= '0; r_zlp <= 1'b0;
                                    r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_SRESET;
                                    r_payload <= '0; r_last <= 1'b0;
                                    r_state <= S_ZLP;
                                    r_cnt <= 4'd8;
                                end
                                default: r_state <= S_IDLE;
                            endcase
                        end
                    end
                    // decide packet: count 8 marks a forced zero packet
                    S_ZLP: begin
                        if (r_cnt == 4'd8) begin
                            r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_ZLP;
                            r_payload <= '0; r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_left != 0) begin
                            r_cnt <= first_cnt[3:0];
                            r_state <= S_DATA;
                        end else begin
                            if (r_zlp) begin
                                r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_ZLP;
                                r_payload <= '0; r_last <= 1'b1;
                                r_zlp <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                    S_DATA: begin
                        r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_DATA;
                        r_payload <= rd; r_last <= (r_cnt == 4'd1);
                        r_ptr <= r_ptr + 8'd1;
                        r_left <= r_left - 7'd1;
                        r_cnt <= r_cnt - 4'd1;
                        if (r_cnt == 4'd1) r_state <= S_IDLE;
                    end
                    S_ADDR: begin
                        r_ovalid <= 1'b1; r_kind <= ucer_pkg::KIND_ADDR;
                        r_payload <= r_addr; r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    logic unused_cfg;
    assign unused_cfg = ^r_cfg;
endmodule

FILE: bench/usb_control_endpoint_responder_tb.sv
module usb_control_endpoint_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_BYTES = (ucer_pkg::EP0_PACKET_BYTES_DEF > 8) ? 8 :
                               ucer_pkg::EP0_PACKET_BYTES_DEF;

    typedef struct {
        logic [1:0]  operation;
        logic [4:0]  byte_count;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] wlen;
    } t_ep0_item;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] payload;
        logic       last;
    } t_ep0_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [4:0]  i_setup_byte_count;
    logic [7:0]  i_request_type;
    logic [7:0]  i_request_code;
    logic [15:0] i_request_value;
    logic [15:0] i_request_length;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [7:0]  o_payload;
    logic        o_last;

    usb_control_endpoint_responder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_setup_byte_count(i_setup_byte_count), .i_request_type(i_request_type),
        .i_request_code(i_request_code), .i_request_value(i_request_value),
        .i_request_length(i_request_length), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_payload(o_payload), .o_last(o_last)
    );

    t_ep0_item  pending_items[$];
    t_ep0_reply expected_replies[$];
    int         sender_idle_pct = 0;
    int         receiver_idle_pct = 0;
    int         mismatch_count = 0;

    // acceptance seen at the last rising edge
    logic o_ready_seen;

    // predictor state
    logic [3:0] lun_reg = '0;
    logic [6:0] bytes_left = '0;
    logic [7:0] rom_ptr = '0;
    logic       zlp_pending = 1'b0;
    logic [7:0] cur_config = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] descriptor_byte(input logic [7:0] a);
        if (a < 8'(ucer_pkg::ROM_USED)) return ucer_pkg::rom_byte(a, 8'(PKT_BYTES));
        if (a == 8'(ucer_pkg::AT_LUN)) return {4'd0, lun_reg};
        return 8'h00;
    endfunction

    function automatic void push_reply(input logic [2:0] kind, input logic [7:0] payload);
        t_ep0_reply r;
        r.kind = kind;
        r.payload = payload;
        r.last = 1'b0;
        expected_replies.push_back(r);
    endfunction

    function automatic void emit_packet();
        int cnt;
        if (bytes_left != 0) begin
            cnt = (bytes_left > PKT_BYTES) ? PKT_BYTES : int'(bytes_left);
            for (int i = 0; i < cnt; i++) begin
                push_reply(ucer_pkg::KIND_DATA, descriptor_byte(rom_ptr));
                rom_ptr = rom_ptr + 8'd1;
            end
            bytes_left = bytes_left - 7'(cnt);
        end else if (zlp_pending) begin
            push_reply(ucer_pkg::KIND_ZLP, 8'h00);
            zlp_pending = 1'b0;
        end
    endfunction

    function automatic void start_reply(input int base, input int len,
                                        input logic [15:0] wlen, input logic force_zlp);
        rom_ptr = 8'(base);
        zlp_pending = force_zlp;
        if (int'(wlen) > len) begin
            bytes_left = 7'(len);
            if (len % PKT_BYTES == 0) zlp_pending = 1'b1;
        end else begin
            bytes_left = wlen[6:0];
        end
        emit_packet();
    endfunction

    function automatic void zero_only();
        bytes_left = '0;
        zlp_pending = 1'b1;
        emit_packet();
    endfunction

    function automatic void decode_setup(input t_ep0_item it);
        logic [1:0] rkind;
        rkind = it.rtype[6:5];
        bytes_left = '0;
        zlp_pending = 1'b0;
        if (it.rtype[7]) begin
            if (rkind == ucer_pkg::RTYPE_STANDARD && it.code == ucer_pkg::REQ_GET_DESCRIPTOR)
            begin
                case (it.value[15:8])
                    ucer_pkg::DESC_DEVICE:
                        start_reply(ucer_pkg::AT_DEV, 18, it.wlen, 1'b0);
                    ucer_pkg::DESC_CONFIGURATION:
                        start_reply(ucer_pkg::AT_CFG, 32, it.wlen, 1'b0);
                    ucer_pkg::DESC_STRING: begin
                        case (it.value[7:0])
                            8'd0: start_reply(ucer_pkg::AT_LANG, 4, it.wlen, 1'b0);
                            8'd1: start_reply(ucer_pkg::AT_MAN, 82, it.wlen, 1'b0);
                            8'd2: start_reply(ucer_pkg::AT_PROD, 42, it.wlen, 1'b0);
                            8'd3: start_reply(ucer_pkg::AT_SER, 22, it.wlen, 1'b0);
                            default: start_reply(0, 0, it.wlen, 1'b1);
                        endcase
                    end
                    ucer_pkg::DESC_REPORT: start_reply(0, 0, it.wlen, 1'b0);
                    default: ;
                endcase
            end else if (rkind == ucer_pkg::RTYPE_CLASS) begin
                if (it.code == ucer_pkg::REQ_GET_MAX_LUN)
                    start_reply(ucer_pkg::AT_LUN, 1, it.wlen, 1'b0);
                else start_reply(0, 0, it.wlen, 1'b1);
            end
        end else if (rkind == ucer_pkg::RTYPE_STANDARD) begin
            case (it.code)
                ucer_pkg::REQ_CLEAR_FEATURE, ucer_pkg::REQ_SET_FEATURE,
                ucer_pkg::REQ_SET_DESCRIPTOR, ucer_pkg::REQ_SET_INTERFACE: ;
                ucer_pkg::REQ_SET_ADDRESS: begin
                    zero_only();
                    push_reply(ucer_pkg::KIND_ADDR, it.value[7:0]);
                end
                ucer_pkg::REQ_SET_CONFIGURATION: begin
                    cur_config = it.value[7:0];
                    push_reply(ucer_pkg::KIND_CONFIG, cur_config);
                    zero_only();
                end
                default: zero_only();
            endcase
        end else if (rkind == ucer_pkg::RTYPE_CLASS) begin
            if (it.code == ucer_pkg::REQ_STORAGE_RESET)
                push_reply(ucer_pkg::KIND_SRESET, 8'h00);
            zero_only();
        end
    endfunction

    // work out the replies one accepted item causes
    function automatic void predict_item(input t_ep0_item it);
        int before_n;
        before_n = expected_replies.size();
        case (it.operation)
            ucer_pkg::OP_BUS_RESET: begin
                bytes_left = '0;
                rom_ptr = '0;
                zlp_pending = 1'b0;
                cur_config = '0;
            end
            ucer_pkg::OP_SETUP: if (it.byte_count == 5'd8) decode_setup(it);
            ucer_pkg::OP_IN_DONE: emit_packet();
            default: ;
        endcase
        if (expected_replies.size() > before_n)
            expected_replies[expected_replies.size() - 1].last = 1'b1;
    endfunction

    function automatic t_ep0_item make_item(input logic [1:0] op, input logic [7:0] rtype,
                                            input logic [7:0] code, input logic [15:0] value,
                                            input logic [15:0] wlen);
        t_ep0_item it;
        it.operation = op;
        it.byte_count = 5'd8;
        it.rtype = rtype;
        it.code = code;
        it.value = value;
        it.wlen = wlen;
        return it;
    endfunction

    function automatic t_ep0_item random_item();
        t_ep0_item it;
        int pick;
        logic [7:0] dtypes[6];
        dtypes = '{ucer_pkg::DESC_DEVICE, ucer_pkg::DESC_CONFIGURATION, ucer_pkg::DESC_STRING,
                   ucer_pkg::DESC_REPORT, 8'h04, 8'h00};
        it = make_item(ucer_pkg::OP_SETUP, 8'($urandom), 8'($urandom), 16'($urandom),
                       16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.operation = ucer_pkg::OP_IN_DONE;
        end else if (pick < 55) begin
            it.rtype = 8'h80 | 8'($urandom_range(0, 31));
            it.code = ucer_pkg::REQ_GET_DESCRIPTOR;
            it.value = {dtypes[$urandom_range(0, 5)], 8'($urandom_range(0, 5))};
            it.wlen = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 140));
        end else if (pick < 63) begin
            it.rtype = 8'hA1;
            it.code = ($urandom_range(0, 1) != 0) ? ucer_pkg::REQ_GET_MAX_LUN : 8'($urandom);
            it.wlen = 16'($urandom_range(0, 3));
        end else if (pick < 75) begin
            it.rtype = 8'($urandom_range(0, 31));
            it.code = 8'($urandom_range(0, 12));
        end else if (pick < 80) begin
            it.rtype = 8'h21;
            it.code = ($urandom_range(0, 1) != 0) ? ucer_pkg::REQ_STORAGE_RESET
                                                  : 8'($urandom);
        end else if (pick < 84) begin
            it.operation = ucer_pkg::OP_BUS_RESET;
        end else if (pick < 87) begin
            it.operation = ucer_pkg::OP_RESERVED;
        end else if (pick < 91) begin
            it.byte_count = 5'($urandom);
        end
        if (pick >= 35 && pick < 84 && $urandom_range(0, 15) == 0)
            it.byte_count = 5'($urandom);
        return it;
    endfunction

    // driver: present queued items, respecting the handshake
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready_seen) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_valid <= 1'b1;
                i_operation <= pending_items[0].operation;
                i_setup_byte_count <= pending_items[0].byte_count;
                i_request_type <= pending_items[0].rtype;
                i_request_code <= pending_items[0].code;
                i_request_value <= pending_items[0].value;
                i_request_length <= pending_items[0].wlen;
                predict_item(pending_items.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // note acceptance for the driver
    always @(posedge i_clk) begin
        o_ready_seen <= i_valid && o_ready;
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_ep0_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_replies.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result kind %0d payload %02h last %0d",
                             o_kind, o_payload, o_last);
            end else begin
                want = expected_replies.pop_front();
                if (want.kind !== o_kind || want.payload !== o_payload
                        || want.last !== o_last) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %0d/%02h/%0d actual %0d/%02h/%0d",
                                 want.kind, want.payload, want.last,
                                 o_kind, o_payload, o_last);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_lun(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        lun_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_directed();
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'hFFFF));
        repeat (3) pending_items.push_back(make_item(ucer_pkg::OP_IN_DONE, 8'h00, 8'h00,
                                                     16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 16'h0040));
        repeat (5) pending_items.push_back(make_item(ucer_pkg::OP_IN_DONE, 8'h00, 8'h00,
                                                     16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 16'h0002));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0307, 16'h0010));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h2200, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h80,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h2200, 16'h0001));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'hA1,
                                          ucer_pkg::REQ_GET_MAX_LUN, 16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'hA1,
                                          ucer_pkg::REQ_GET_MAX_LUN, 16'h0000, 16'h0001));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h00,
                                          ucer_pkg::REQ_SET_ADDRESS, 16'hFF2A, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h00,
                                          ucer_pkg::REQ_SET_CONFIGURATION, 16'h00FF,
                                          16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h21,
                                          ucer_pkg::REQ_STORAGE_RESET, 16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h21, 8'h00,
                                          16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'hC0,
                                          ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'h0012));
        pending_items.push_back(make_item(ucer_pkg::OP_SETUP, 8'h00,
                                          ucer_pkg::REQ_CLEAR_FEATURE, 16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_BUS_RESET, 8'h00, 8'h00,
                                          16'h0000, 16'h0000));
        pending_items.push_back(make_item(ucer_pkg::OP_RESERVED, 8'hFF, 8'hFF,
                                          16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_item(ucer_pkg::OP_IN_DONE, 8'h00, 8'h00,
                                          16'h0000, 16'h0000));
        pending_items[$].byte_count = 5'd31;
    endtask

    // timeout
    initial begin
        #20ms;
        $display("usb_control_endpoint_responder_tb failed");
        $finish;
    end

    initial begin
        t_ep0_item it;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the largest LUN setting
        write_lun(4'd15);
        add_directed();
        wait_drained();

        // random part in three idling phases, LUN changed between them
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
            receiver_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
            write_lun((phase == 0) ? 4'd0 : 4'($urandom));
            for (int n = 0; n < 130; n++) begin
                it = random_item();
                pending_items.push_back(it);
                // hold off until all results have come
                if (n == 60) wait_drained();
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("usb_control_endpoint_responder_tb passed");
        else
            $display("usb_control_endpoint_responder_tb failed");
        $finish;
    end
endmodule
